>>> rtl/core/rmq_pkg.sv
// Package for the rotation matrix to quaternion pipeline.
// Holds the shared widths, the lead-component code and the sign-extension and saturation helpers.
// No dependencies.
package rmq_pkg;

  // Number format: signed Q2.14 on every port
  localparam int DATA_W    = 16;
  localparam int FRAC_BITS = 14;
  localparam int NUM_IN    = 9;
  localparam int NUM_OUT   = 4;
  localparam int IN_W      = NUM_IN * DATA_W;
  localparam int OUT_W     = NUM_OUT * DATA_W;

  // Internal widths
  localparam int SUM_W  = DATA_W + 3;          // signed root argument before clamp
  localparam int ARG_W  = DATA_W + 1;          // clamped root argument, unsigned
  localparam int NUM_W  = DATA_W + 1;          // signed numerator
  localparam int RAD_W  = 2 * DATA_W;          // radicand, argument scaled by 2^FRAC_BITS
  localparam int ROOT_W = RAD_W / 2;           // root width
  localparam int SREM_W = ROOT_W + 3;          // root remainder
  localparam int DIV_W  = ROOT_W + 1;          // divisor 2*r
  localparam int QUO_W  = DIV_W;               // quotient bits kept
  localparam int DREM_W = DIV_W + 1;           // divider remainder
  localparam int HI_W   = NUM_W - (QUO_W - FRAC_BITS); // dividend bits above the quotient

  localparam int SQ_STEPS = ROOT_W;
  localparam int DV_STEPS = QUO_W;

  localparam logic signed [SUM_W-1:0] ONE_Q = SUM_W'(1) << FRAC_BITS;

  localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  // Which quaternion component comes straight from the root
  typedef enum logic [1:0] {
    LEAD_W = 2'd0,
    LEAD_X = 2'd1,
    LEAD_Y = 2'd2,
    LEAD_Z = 2'd3
  } lead_t;

  function automatic logic signed [NUM_W-1:0] sx_num(input logic signed [DATA_W-1:0] v);
    return {v[DATA_W-1], v};
  endfunction

  function automatic logic signed [SUM_W-1:0] sx_sum(input logic signed [DATA_W-1:0] v);
    return {{(SUM_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  // Signed saturation of a sign/magnitude quotient
  function automatic logic [DATA_W-1:0] sat_quo(input logic neg, input logic ovf,
                                                input logic [QUO_W-1:0] q);
    logic [QUO_W-1:0] lim;
    lim = QUO_W'(SAT_NEG);
    if (!neg) begin
      if (ovf || q > QUO_W'(SAT_POS)) return SAT_POS;
      return q[DATA_W-1:0];
    end
    if (ovf || q > lim) return SAT_NEG;
    return DATA_W'(-q[DATA_W-1:0]);
  endfunction

endpackage

>>> rtl/core/rotation_matrix_to_quaternion.sv
// Top level of the rotation matrix to quaternion pipeline (Shoemake's method).
// Depends on rmq_pkg for widths, the lead code and the sign-extension and saturation helpers.
//
// Usage:
//   Input channel in_*: one 3x3 matrix per item, nine signed Q2.14 entries.
//   Output channel out_*: one quaternion w, x, y, z per item, signed Q2.14,
//   saturated to the 16-bit range.
//   Pipeline: each item taken passes 37 register stages (two front
//   stages, 16 root steps, a divider set-up stage, 17 divider steps and
//   the output register), the first of which it enters at the accepting
//   edge; its result then shows on out_tvalid.
//   Throughput: one item per cycle while not stalled; each root and divider stage does one bit.
//   A new item is taken in every cycle in which the output register is empty
//   or being read.
//   Stall: while out_tvalid is high and out_tready low, the whole pipeline
//   holds and in_tready is low; nothing is lost or repeated.
//   Reset: rst_n low clears every valid bit; items in flight are dropped.
//   A zero root gives zero for the three non-leading components.
module rotation_matrix_to_quaternion (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 from the lowest bit up
  input  logic [rmq_pkg::IN_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // quat_w, quat_x, quat_y, quat_z from the lowest bit up
  output logic [rmq_pkg::OUT_W-1:0] out_tdata
);
  import rmq_pkg::*;

  logic en;

  // Global advance: the output register is free or being emptied
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------- stage 0: capture, trace sign, largest diagonal
  logic signed [DATA_W-1:0] m_in [NUM_IN];
  logic signed [SUM_W-1:0]  trace_in;
  logic                     g1_in, g2_in;
  logic signed [DATA_W-1:0] dmax_in;
  lead_t                    lead_in;

  logic                     v0_r;
  logic signed [DATA_W-1:0] m_r [NUM_IN];
  lead_t                    lead0_r;

  always_comb begin
    for (int k = 0; k < NUM_IN; k++) begin
      m_in[k] = in_tdata[k*DATA_W +: DATA_W];
    end
    trace_in = sx_sum(m_in[0]) + sx_sum(m_in[4]) + sx_sum(m_in[8]);
    g1_in    = m_in[4] > m_in[0];
    dmax_in  = g1_in ? m_in[4] : m_in[0];
    g2_in    = m_in[8] > dmax_in;
    if (!trace_in[SUM_W-1] && trace_in != '0) lead_in = LEAD_W;
    else if (g2_in)                             lead_in = LEAD_Z;
    else if (g1_in)                             lead_in = LEAD_Y;
    else                                        lead_in = LEAD_X;
  end

  // ---------------- stage 1: root argument and numerators
  logic signed [DATA_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [SUM_W-1:0]  a_raw;
  logic [ARG_W-1:0]         a_nxt;
  logic signed [NUM_W-1:0]  n_nxt [NUM_OUT];

  logic                     v1_r;
  lead_t                    lead1_r;
  logic [ARG_W-1:0]         a1_r;
  logic signed [NUM_W-1:0]  n1_r [NUM_OUT];

  assign m00 = m_r[0];
  assign m01 = m_r[1];
  assign m02 = m_r[2];
  assign m10 = m_r[3];
  assign m11 = m_r[4];
  assign m12 = m_r[5];
  assign m20 = m_r[6];
  assign m21 = m_r[7];
  assign m22 = m_r[8];

  always_comb begin
    unique case (lead0_r)
      LEAD_W: begin
        a_raw    = sx_sum(m00) + sx_sum(m11) + sx_sum(m22) + ONE_Q;
        n_nxt[0] = '0;
        n_nxt[1] = sx_num(m21) - sx_num(m12);
        n_nxt[2] = sx_num(m02) - sx_num(m20);
        n_nxt[3] = sx_num(m10) - sx_num(m01);
      end
      LEAD_X: begin
        a_raw    = sx_sum(m00) - sx_sum(m11) - sx_sum(m22) + ONE_Q;
        n_nxt[0] = sx_num(m21) - sx_num(m12);
        n_nxt[1] = '0;
        n_nxt[2] = sx_num(m10) + sx_num(m01);
        n_nxt[3] = sx_num(m20) + sx_num(m02);
      end
      LEAD_Y: begin
        a_raw    = sx_sum(m11) - sx_sum(m22) - sx_sum(m00) + ONE_Q;
        n_nxt[0] = sx_num(m02) - sx_num(m20);
        n_nxt[1] = sx_num(m01) + sx_num(m10);
        n_nxt[2] = '0;
        n_nxt[3] = sx_num(m21) + sx_num(m12);
      end
      LEAD_Z: begin
        a_raw    = sx_sum(m22) - sx_sum(m00) - sx_sum(m11) + ONE_Q;
        n_nxt[0] = sx_num(m10) - sx_num(m01);
        n_nxt[1] = sx_num(m02) + sx_num(m20);
        n_nxt[2] = sx_num(m12) + sx_num(m21);
        n_nxt[3] = '0;
      end
      default: begin
        a_raw = '0;
        for (int l = 0; l < NUM_OUT; l++) n_nxt[l] = '0;
      end
    endcase
    // negative argument clamps to zero
    a_nxt = a_raw[SUM_W-1] ? '0 : a_raw[ARG_W-1:0];
  end

  // ---------------- root: one result bit per stage
  logic                     sq_v_r    [SQ_STEPS];
  lead_t                    sq_lead_r [SQ_STEPS];
  logic [RAD_W-1:0]         sq_x_r    [SQ_STEPS];
  logic [SREM_W-1:0]        sq_rem_r  [SQ_STEPS];
  logic [ROOT_W-1:0]        sq_root_r [SQ_STEPS];
  logic signed [NUM_W-1:0]  sq_n_r    [SQ_STEPS][NUM_OUT];

  logic [RAD_W-1:0]         sq_x_nxt    [SQ_STEPS];
  logic [SREM_W-1:0]        sq_rem_nxt  [SQ_STEPS];
  logic [ROOT_W-1:0]        sq_root_nxt [SQ_STEPS];

  always_comb begin
    logic [RAD_W-1:0]  x_in;
    logic [SREM_W-1:0] rem_in, rem_sh, trial;
    logic [ROOT_W-1:0] root_in;
    for (int s = 0; s < SQ_STEPS; s++) begin
      if (s == 0) begin
        x_in    = RAD_W'(a1_r) << FRAC_BITS;
        rem_in  = '0;
        root_in = '0;
      end else begin
        x_in    = sq_x_r[s-1];
        rem_in  = sq_rem_r[s-1];
        root_in = sq_root_r[s-1];
      end
      rem_sh = {rem_in[SREM_W-3:0], x_in[RAD_W-1 -: 2]};
      trial  = {1'b0, root_in, 2'b01};
      if (rem_sh >= trial) begin
        sq_rem_nxt[s]  = rem_sh - trial;
        sq_root_nxt[s] = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem_nxt[s]  = rem_sh;
        sq_root_nxt[s] = {root_in[ROOT_W-2:0], 1'b0};
      end
      sq_x_nxt[s] = x_in << 2;
    end
  end

  // ---------------- divider set-up: magnitudes, overflow, first remainder
  logic [ROOT_W-1:0]        r_fin;
  logic [DIV_W-1:0]         d_nxt;

  logic                     dp_v_r;
  lead_t                    dp_lead_r;
  logic [ROOT_W-1:0]        dp_r_r;
  logic [DIV_W-1:0]         dp_d_r;
  logic                     dp_neg_r [NUM_OUT];
  logic                     dp_ovf_r [NUM_OUT];
  logic [DREM_W-1:0]        dp_rem_r [NUM_OUT];
  logic [QUO_W-1:0]         dp_nb_r  [NUM_OUT];

  logic [NUM_W-1:0]         mag_nxt  [NUM_OUT];
  logic                     ovf_nxt  [NUM_OUT];

  assign r_fin = sq_root_r[SQ_STEPS-1];
  assign d_nxt = {r_fin, 1'b0};

  always_comb begin
    for (int l = 0; l < NUM_OUT; l++) begin
      mag_nxt[l] = sq_n_r[SQ_STEPS-1][l][NUM_W-1] ? NUM_W'(-sq_n_r[SQ_STEPS-1][l])
                                                   : NUM_W'(sq_n_r[SQ_STEPS-1][l]);
      ovf_nxt[l] = DIV_W'(mag_nxt[l][NUM_W-1 -: HI_W]) >= d_nxt;
    end
  end

  // ---------------- divider: one quotient bit per stage, four lanes
  logic                     dv_v_r    [DV_STEPS];
  lead_t                    dv_lead_r [DV_STEPS];
  logic [ROOT_W-1:0]        dv_r_r    [DV_STEPS];
  logic [DIV_W-1:0]         dv_d_r    [DV_STEPS];
  logic                     dv_neg_r  [DV_STEPS][NUM_OUT];
  logic                     dv_ovf_r  [DV_STEPS][NUM_OUT];
  logic [DREM_W-1:0]        dv_rem_r  [DV_STEPS][NUM_OUT];
  logic [QUO_W-1:0]         dv_nb_r   [DV_STEPS][NUM_OUT];
  logic [QUO_W-1:0]         dv_q_r    [DV_STEPS][NUM_OUT];

  logic [DREM_W-1:0]        dv_rem_nxt [DV_STEPS][NUM_OUT];
  logic [QUO_W-1:0]         dv_nb_nxt  [DV_STEPS][NUM_OUT];
  logic [QUO_W-1:0]         dv_q_nxt   [DV_STEPS][NUM_OUT];

  always_comb begin
    logic [DREM_W-1:0] rem_in, rem_sh;
    logic [QUO_W-1:0]  nb_in, q_in;
    logic [DIV_W-1:0]  d_in;
    for (int s = 0; s < DV_STEPS; s++) begin
      for (int l = 0; l < NUM_OUT; l++) begin
        if (s == 0) begin
          rem_in = dp_rem_r[l];
          nb_in  = dp_nb_r[l];
          q_in   = '0;
          d_in   = dp_d_r;
        end else begin
          rem_in = dv_rem_r[s-1][l];
          nb_in  = dv_nb_r[s-1][l];
          q_in   = dv_q_r[s-1][l];
          d_in   = dv_d_r[s-1];
        end
        rem_sh = {rem_in[DREM_W-2:0], nb_in[QUO_W-1]};
        if (rem_sh >= {1'b0, d_in}) begin
          dv_rem_nxt[s][l] = rem_sh - {1'b0, d_in};
          dv_q_nxt[s][l]   = {q_in[QUO_W-2:0], 1'b1};
        end else begin
          dv_rem_nxt[s][l] = rem_sh;
          dv_q_nxt[s][l]   = {q_in[QUO_W-2:0], 1'b0};
        end
        dv_nb_nxt[s][l] = nb_in << 1;
      end
    end
  end

  // ---------------- output selection: lead from the root, others saturated, or zero for a zero root
  logic [OUT_W-1:0] out_nxt;
  logic             out_tvalid_r;
  logic [OUT_W-1:0] out_tdata_r;

  always_comb begin
    for (int l = 0; l < NUM_OUT; l++) begin
      if (dv_lead_r[DV_STEPS-1] == lead_t'(l)) begin
        out_nxt[l*DATA_W +: DATA_W] = DATA_W'(dv_r_r[DV_STEPS-1] >> 1);
      end else if (dv_r_r[DV_STEPS-1] == '0) begin
        out_nxt[l*DATA_W +: DATA_W] = '0;
      end else begin
        out_nxt[l*DATA_W +: DATA_W] = sat_quo(dv_neg_r[DV_STEPS-1][l],
                                              dv_ovf_r[DV_STEPS-1][l],
                                              dv_q_r[DV_STEPS-1][l]);
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // ---------------- valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r         <= 1'b0;
      v1_r         <= 1'b0;
      dp_v_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
      for (int s = 0; s < SQ_STEPS; s++) sq_v_r[s] <= 1'b0;
      for (int s = 0; s < DV_STEPS; s++) dv_v_r[s] <= 1'b0;
    end else if (en) begin
      v0_r         <= in_tvalid;
      v1_r         <= v0_r;
      sq_v_r[0]    <= v1_r;
      for (int s = 1; s < SQ_STEPS; s++) sq_v_r[s] <= sq_v_r[s-1];
      dp_v_r       <= sq_v_r[SQ_STEPS-1];
      dv_v_r[0]    <= dp_v_r;
      for (int s = 1; s < DV_STEPS; s++) dv_v_r[s] <= dv_v_r[s-1];
      out_tvalid_r <= dv_v_r[DV_STEPS-1];
    end
  end

  // ---------------- payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_IN; k++) m_r[k] <= m_in[k];
      lead0_r <= lead_in;

      lead1_r <= lead0_r;
      a1_r    <= a_nxt;
      for (int l = 0; l < NUM_OUT; l++) n1_r[l] <= n_nxt[l];

      for (int s = 0; s < SQ_STEPS; s++) begin
        sq_lead_r[s] <= (s == 0) ? lead1_r : sq_lead_r[s > 0 ? s-1 : 0];
        sq_x_r[s]    <= sq_x_nxt[s];
        sq_rem_r[s]  <= sq_rem_nxt[s];
        sq_root_r[s] <= sq_root_nxt[s];
        for (int l = 0; l < NUM_OUT; l++) begin
          sq_n_r[s][l] <= (s == 0) ? n1_r[l] : sq_n_r[s > 0 ? s-1 : 0][l];
        end
      end

      dp_lead_r <= sq_lead_r[SQ_STEPS-1];
      dp_r_r    <= r_fin;
      dp_d_r    <= d_nxt;
      for (int l = 0; l < NUM_OUT; l++) begin
        dp_neg_r[l] <= sq_n_r[SQ_STEPS-1][l][NUM_W-1];
        dp_ovf_r[l] <= ovf_nxt[l];
        dp_rem_r[l] <= DREM_W'(mag_nxt[l][NUM_W-1 -: HI_W]);
        dp_nb_r[l]  <= QUO_W'(mag_nxt[l][NUM_W-HI_W-1:0]) << FRAC_BITS;
      end

      for (int s = 0; s < DV_STEPS; s++) begin
        dv_lead_r[s] <= (s == 0) ? dp_lead_r : dv_lead_r[s > 0 ? s-1 : 0];
        dv_r_r[s]    <= (s == 0) ? dp_r_r    : dv_r_r[s > 0 ? s-1 : 0];
        dv_d_r[s]    <= (s == 0) ? dp_d_r    : dv_d_r[s > 0 ? s-1 : 0];
        for (int l = 0; l < NUM_OUT; l++) begin
          dv_neg_r[s][l] <= (s == 0) ? dp_neg_r[l] : dv_neg_r[s > 0 ? s-1 : 0][l];
          dv_ovf_r[s][l] <= (s == 0) ? dp_ovf_r[l] : dv_ovf_r[s > 0 ? s-1 : 0][l];
          dv_rem_r[s][l] <= dv_rem_nxt[s][l];
          dv_nb_r[s][l]  <= dv_nb_nxt[s][l];
          dv_q_r[s][l]   <= dv_q_nxt[s][l];
        end
      end

      out_tdata_r <= out_nxt;
    end
  end

endmodule

>>> rtl/core/rmq_checker.sv
// Port-level checks for the rotation matrix to quaternion pipeline.
// Depends on rmq_pkg for port widths; bound to the top level below.
module rmq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [rmq_pkg::OUT_W-1:0]   out_tdata
);
  import rmq_pkg::*;

  // a held result keeps its valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // a held result keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  // a stalled output stalls the input
  a_back_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("item taken while the output is stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown straight after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);

>>> tb/tb_rotation_matrix_to_quaternion.sv
// Testbench for the rotation matrix to quaternion pipeline.
// Predicts each quaternion in fixed point and checks results in order.
// Depends on rmq_pkg and rotation_matrix_to_quaternion.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;
  import rmq_pkg::*;

  localparam int ONE = 1 << FRAC_BITS;
  localparam int LATENCY = 37;

  typedef logic signed [DATA_W-1:0] q_t;
  typedef struct packed {q_t z; q_t y; q_t x; q_t w;} quat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  quat_t expected_quats[$];
  int mismatches = 0;
  bit idle_en = 1'b1;

  rotation_matrix_to_quaternion i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // floor of the square root, bit by bit
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic q_t clip16(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return q_t'(v);
  endfunction

  // n * 2^F / (2r), truncated toward zero
  function automatic longint frac_div(input longint n, input longint r);
    if (r == 0) return 0;
    return (n * ONE) / (2 * r);
  endfunction

  function automatic quat_t predict_quat(input logic [IN_W-1:0] mat);
    longint m[3][3];
    longint tr, r, a, qw;
    longint q[3];
    int i, j, k;
    quat_t res;
    for (int e = 0; e < 9; e++)
      m[e/3][e%3] = longint'($signed(mat[e*DATA_W +: DATA_W]));
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      r = longint'(int_sqrt(longint'(tr + ONE) << FRAC_BITS));
      qw = r >>> 1;
      q[0] = frac_div(m[2][1] - m[1][2], r);
      q[1] = frac_div(m[0][2] - m[2][0], r);
      q[2] = frac_div(m[1][0] - m[0][1], r);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      a = m[i][i] - (m[j][j] + m[k][k]) + ONE;
      if (a < 0) a = 0;
      r = longint'(int_sqrt(a << FRAC_BITS));
      q[i] = r >>> 1;
      qw = frac_div(m[k][j] - m[j][k], r);
      q[j] = frac_div(m[j][i] + m[i][j], r);
      q[k] = frac_div(m[k][i] + m[i][k], r);
    end
    res.w = clip16(qw);
    res.x = clip16(q[0]);
    res.y = clip16(q[1]);
    res.z = clip16(q[2]);
    return res;
  endfunction

  function automatic logic [IN_W-1:0] pack_mat(input int e[9]);
    logic [IN_W-1:0] v;
    for (int n = 0; n < 9; n++) v[n*DATA_W +: DATA_W] = DATA_W'(e[n]);
    return v;
  endfunction

  // send one matrix, with random gaps before it
  task automatic send_matrix(input logic [IN_W-1:0] mat);
    while (idle_en && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= mat;
    expected_quats.push_back(predict_quat(mat));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic go_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // output side: random stalls and in-order checking
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_quats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected quaternion %h", out_tdata);
        end else begin
          quat_t exp_q, got;
          exp_q = expected_quats.pop_front();
          got = out_tdata;
          if (got !== exp_q) begin
            mismatches++;
            if (mismatches <= 10)
              $display("quaternion mismatch: expected w%0d x%0d y%0d z%0d, got w%0d x%0d y%0d z%0d",
                       exp_q.w, exp_q.x, exp_q.y, exp_q.z, got.w, got.x, got.y, got.z);
          end
        end
      end
      out_tready <= !(idle_en && $urandom_range(99) < 18);
    end
  end

  task automatic test_directed();
    int e[9];
    int ext[4] = '{-32768, 32767, 0, ONE};
    // identity and axis rotations by 180 degrees
    e = '{ONE,0,0, 0,ONE,0, 0,0,ONE}; send_matrix(pack_mat(e));
    e = '{ONE,0,0, 0,-ONE,0, 0,0,-ONE}; send_matrix(pack_mat(e));
    e = '{-ONE,0,0, 0,ONE,0, 0,0,-ONE}; send_matrix(pack_mat(e));
    e = '{-ONE,0,0, 0,-ONE,0, 0,0,ONE}; send_matrix(pack_mat(e));
    // 90 degrees about z
    e = '{0,-ONE,0, ONE,0,0, 0,0,ONE}; send_matrix(pack_mat(e));
    // all zero: zero trace, ties on the diagonal
    e = '{0,0,0, 0,0,0, 0,0,0}; send_matrix(pack_mat(e));
    // extreme diagonals: a large positive trace, then all three at -32768
    e = '{-32768,5,7, 9,32767,3, 2,1,32767}; send_matrix(pack_mat(e));
    e = '{-32768,100,-100, 50,-32768,9, 8,7,-32768}; send_matrix(pack_mat(e));
    // extremes everywhere
    e = '{32767,-32768,32767, -32768,32767,-32768, 32767,-32768,32767};
    send_matrix(pack_mat(e));
    e = '{-32768,32767,-32768, 32767,-32768,32767, -32768,32767,-32768};
    send_matrix(pack_mat(e));
    e = '{0,32767,32767, 32767,0,32767, 32767,32767,-1}; send_matrix(pack_mat(e));
    e = '{1,-32768,-32768, -32768,-1,-32768, -32768,-32768,0}; send_matrix(pack_mat(e));
    // ties between two diagonal entries
    e = '{-100,3,4, 5,-100,6, 7,8,-200}; send_matrix(pack_mat(e));
    e = '{-200,3,4, 5,-100,6, 7,8,-100}; send_matrix(pack_mat(e));
    for (int t = 0; t < 8; t++) begin
      for (int n = 0; n < 9; n++) e[n] = ext[$urandom_range(3)];
      send_matrix(pack_mat(e));
    end
    go_idle();
  endtask

  task automatic test_random(input int count);
    int e[9];
    real ang, c, s;
    for (int t = 0; t < count; t++) begin
      if (t % 3 == 0) begin
        // raw bit patterns
        for (int n = 0; n < 9; n++) e[n] = int'($urandom_range(65535)) - 32768;
      end else begin
        // near-rotation about a randomly chosen x, y or z axis, plus noise
        ang = $urandom_range(6283) / 1000.0;
        c = $cos(ang) * ONE;
        s = $sin(ang) * ONE;
        case ($urandom_range(2))
          0: e = '{ONE,0,0, 0,int'(c),-int'(s), 0,int'(s),int'(c)};
          1: e = '{int'(c),0,int'(s), 0,ONE,0, -int'(s),0,int'(c)};
          default: e = '{int'(c),-int'(s),0, int'(s),int'(c),0, 0,0,ONE};
        endcase
        for (int n = 0; n < 9; n++) e[n] += int'($urandom_range(64)) - 32;
      end
      send_matrix(pack_mat(e));
    end
    go_idle();
  endtask

  task automatic drain();
    while (expected_quats.size() != 0) @(posedge clk);
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    test_random(120);
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain();
    test_random(200);
    drain();
    test_no_idle();
    test_random(180);
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
